@@ src/vn2d_pkg.sv @@
// shared constants for the 2d vector normalizer
// no dependencies; used by vector_normalize_2d_core and vn2d_div_pipe
package vn2d_pkg;

    // result component width and saturation limits
    localparam int OUT_WIDTH = 16;
    localparam logic [31:0] POS_LIMIT = 32'd32767;
    localparam logic [31:0] NEG_LIMIT = 32'd32768;

    // sideband that rides along the divider stages
    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic zero;
    } div_side_t;

endpackage

@@ src/vn2d_sqrt_pipe.sv @@
// pipelined floor square root, one root bit per register stage
// depends on nothing; instanced by vector_normalize_2d_core
module vn2d_sqrt_pipe #(
    parameter int W  = 32,
    parameter int SW = 67
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             ce,
    input  logic             in_valid,
    input  logic [2*W-1:0]   in_rad,
    input  logic [SW-1:0]    in_side,
    output logic             out_valid,
    output logic [W-1:0]     out_root,
    output logic [SW-1:0]    out_side
);

    localparam int RW = W + 2;

    logic           valid_reg [W+1];
    logic [2*W-1:0] rad_reg   [W+1];
    logic [RW-1:0]  rem_reg   [W+1];
    logic [W-1:0]   root_reg  [W+1];
    logic [SW-1:0]  side_reg  [W+1];

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (ce) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rad_reg[0]  <= in_rad;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            side_reg[0] <= in_side;
        end
    end

    // one restoring root step per stage
    for (genvar k = 0; k < W; k++) begin : g_step
        logic [RW+1:0] cur;
        logic [RW+1:0] trial;
        logic [RW+1:0] diff;
        logic          ge;

        always_comb begin
            cur   = {rem_reg[k], rad_reg[k][2*W-1:2*W-2]};
            trial = {2'b00, root_reg[k], 2'b01};
            diff  = cur - trial;
            ge    = (cur >= trial);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k+1] <= 1'b0;
            end else if (ce) begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rad_reg[k+1]  <= {rad_reg[k][2*W-3:0], 2'b00};
                rem_reg[k+1]  <= ge ? diff[RW-1:0] : cur[RW-1:0];
                root_reg[k+1] <= {root_reg[k][W-2:0], ge};
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = valid_reg[W];
    assign out_root  = root_reg[W];
    assign out_side  = side_reg[W];

endmodule

@@ src/vn2d_div_pipe.sv @@
// pipelined restoring divider for both components, one quotient bit per stage
// depends on vn2d_pkg; instanced by vector_normalize_2d_core
module vn2d_div_pipe #(
    parameter int W = 32,
    parameter int F = 14
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  ce,
    input  logic                  in_valid,
    input  logic [W-1:0]          in_len,
    input  logic [W-1:0]          in_mag_x,
    input  logic [W-1:0]          in_mag_y,
    input  vn2d_pkg::div_side_t   in_side,
    output logic                  out_valid,
    output logic [F:0]            out_q_x,
    output logic [F:0]            out_q_y,
    output vn2d_pkg::div_side_t   out_side
);

    localparam int NS = F + 1;

    logic                valid_reg [NS+1];
    logic [W-1:0]        len_reg   [NS+1];
    logic [W-1:0]        rx_reg    [NS+1];
    logic [W-1:0]        ry_reg    [NS+1];
    logic                bx_reg    [NS+1];
    logic                by_reg    [NS+1];
    logic [F:0]          qx_reg    [NS+1];
    logic [F:0]          qy_reg    [NS+1];
    vn2d_pkg::div_side_t side_reg  [NS+1];

    // input register: quotient fits F+1 bits, so start from mag >> 1
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (ce) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            len_reg[0]  <= in_len;
            rx_reg[0]   <= {1'b0, in_mag_x[W-1:1]};
            ry_reg[0]   <= {1'b0, in_mag_y[W-1:1]};
            bx_reg[0]   <= in_mag_x[0];
            by_reg[0]   <= in_mag_y[0];
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
            side_reg[0] <= in_side;
        end
    end

    // one quotient bit per stage for each component
    for (genvar k = 0; k < NS; k++) begin : g_step
        logic [W:0] cur_x;
        logic [W:0] cur_y;
        logic [W:0] dvs;
        logic [W:0] dif_x;
        logic [W:0] dif_y;
        logic       ge_x;
        logic       ge_y;

        always_comb begin
            cur_x = {rx_reg[k], bx_reg[k]};
            cur_y = {ry_reg[k], by_reg[k]};
            dvs   = {1'b0, len_reg[k]};
            dif_x = cur_x - dvs;
            dif_y = cur_y - dvs;
            ge_x  = (cur_x >= dvs);
            ge_y  = (cur_y >= dvs);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k+1] <= 1'b0;
            end else if (ce) begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                len_reg[k+1]  <= len_reg[k];
                rx_reg[k+1]   <= ge_x ? dif_x[W-1:0] : cur_x[W-1:0];
                ry_reg[k+1]   <= ge_y ? dif_y[W-1:0] : cur_y[W-1:0];
                bx_reg[k+1]   <= 1'b0;
                by_reg[k+1]   <= 1'b0;
                qx_reg[k+1]   <= {qx_reg[k][F-1:0], ge_x};
                qy_reg[k+1]   <= {qy_reg[k][F-1:0], ge_y};
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = valid_reg[NS];
    assign out_q_x   = qx_reg[NS];
    assign out_q_y   = qy_reg[NS];
    assign out_side  = side_reg[NS];

endmodule

@@ src/vector_normalize_2d_core.sv @@
// top level of the 2d vector normalizer
// depends on vn2d_pkg, vn2d_sqrt_pipe and vn2d_div_pipe
//
// usage:
//   s_ channel: one vector per transfer, s_tdata = {comp_y, comp_x}, low IN_WIDTH
//   bits of each 32-bit component read as two's complement (Q16.16 by default).
//   m_ channel: one result per input, m_tdata = {unit_y, unit_x} as signed
//   Q2.14 (OUT_FRAC_BITS fraction bits), m_tuser = was_zero for a zero vector.
//   each result passes through the square root stages (one root bit each) and
//   then the divider stages (one quotient bit each); throughput one vector per
//   cycle while the receiver does not stall.
//   the whole pipeline advances together; when the receiver stalls with a result
//   held in the output register, every stage holds and s_tready drops, so
//   nothing is lost or repeated.
//   reset (aresetn low, synchronous) clears all stage valid bits; data is kept.
module vector_normalize_2d_core #(
    parameter int IN_WIDTH      = 32,
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] comp_x, [63:32] comp_y
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] unit_x, [31:16] unit_y
    output logic        m_tuser    // [0] was_zero
);

    localparam int W  = IN_WIDTH;
    localparam int F  = OUT_FRAC_BITS;
    localparam int SW = 2 * W + 3;
    localparam int OW = vn2d_pkg::OUT_WIDTH;

    logic ce;

    // global advance: output register empty or being taken
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    // stage a: sign and magnitude
    logic [W-1:0] vx;
    logic [W-1:0] vy;
    logic         a_valid_reg;
    logic [W-1:0] a_mx_reg;
    logic [W-1:0] a_my_reg;
    logic         a_nx_reg;
    logic         a_ny_reg;

    assign vx = s_tdata[W-1:0];
    assign vy = s_tdata[32+W-1:32];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (ce) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            a_mx_reg <= vx[W-1] ? (~vx + 1'b1) : vx;
            a_my_reg <= vy[W-1] ? (~vy + 1'b1) : vy;
            a_nx_reg <= vx[W-1];
            a_ny_reg <= vy[W-1];
        end
    end

    // stage b: squares
    logic           b_valid_reg;
    logic [2*W-1:0] b_sx_reg;
    logic [2*W-1:0] b_sy_reg;
    logic [SW-1:0]  b_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (ce) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            b_sx_reg   <= a_mx_reg * a_mx_reg;
            b_sy_reg   <= a_my_reg * a_my_reg;
            b_side_reg <= {a_mx_reg, a_my_reg, a_nx_reg, a_ny_reg,
                           (a_mx_reg == '0) && (a_my_reg == '0)};
        end
    end

    // stage c: sum of squares
    logic           c_valid_reg;
    logic [2*W-1:0] c_sum_reg;
    logic [SW-1:0]  c_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (ce) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            c_sum_reg  <= b_sx_reg + b_sy_reg;
            c_side_reg <= b_side_reg;
        end
    end

    // length
    logic          r_valid;
    logic [W-1:0]  r_len;
    logic [SW-1:0] r_side;

    vn2d_sqrt_pipe #(
        .W  (W),
        .SW (SW)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (c_valid_reg),
        .in_rad    (c_sum_reg),
        .in_side   (c_side_reg),
        .out_valid (r_valid),
        .out_root  (r_len),
        .out_side  (r_side)
    );

    // per-component division
    vn2d_pkg::div_side_t d_in_side;
    vn2d_pkg::div_side_t d_side;
    logic                d_valid;
    logic [F:0]          d_qx;
    logic [F:0]          d_qy;

    assign d_in_side.neg_x = r_side[2];
    assign d_in_side.neg_y = r_side[1];
    assign d_in_side.zero  = r_side[0];

    vn2d_div_pipe #(
        .W (W),
        .F (F)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (r_valid),
        .in_len    (r_len),
        .in_mag_x  (r_side[SW-1:W+3]),
        .in_mag_y  (r_side[W+2:3]),
        .in_side   (d_in_side),
        .out_valid (d_valid),
        .out_q_x   (d_qx),
        .out_q_y   (d_qy),
        .out_side  (d_side)
    );

    // saturate and apply sign
    logic [31:0] qx32;
    logic [31:0] qy32;
    logic [16:0] mag_x;
    logic [16:0] mag_y;
    logic [OW-1:0] ux;
    logic [OW-1:0] uy;

    always_comb begin
        qx32 = 32'(d_qx);
        qy32 = 32'(d_qy);
        if (d_side.neg_x) begin
            mag_x = (qx32 > vn2d_pkg::NEG_LIMIT) ? vn2d_pkg::NEG_LIMIT[16:0] : qx32[16:0];
            ux    = OW'(17'h10000 - mag_x);
        end else begin
            mag_x = (qx32 > vn2d_pkg::POS_LIMIT) ? vn2d_pkg::POS_LIMIT[16:0] : qx32[16:0];
            ux    = mag_x[OW-1:0];
        end
        if (d_side.neg_y) begin
            mag_y = (qy32 > vn2d_pkg::NEG_LIMIT) ? vn2d_pkg::NEG_LIMIT[16:0] : qy32[16:0];
            uy    = OW'(17'h10000 - mag_y);
        end else begin
            mag_y = (qy32 > vn2d_pkg::POS_LIMIT) ? vn2d_pkg::POS_LIMIT[16:0] : qy32[16:0];
            uy    = mag_y[OW-1:0];
        end
    end

    // output register
    logic          out_valid_reg;
    logic [31:0]   out_data_reg;
    logic          out_zero_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ce) begin
            out_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_data_reg <= d_side.zero ? 32'd0 : {uy, ux};
            out_zero_reg <= d_side.zero;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_zero_reg;

endmodule
